// ===== design/dependency_graph_topo_sort_cull_top_defines.svh =====
// ----------------------------------------------------------------------------
// Dependency graph scheduler assertion macros
// Shared property forms for the top level checks.
// ----------------------------------------------------------------------------
`ifndef DEPENDENCY_GRAPH_TOPO_SORT_CULL_TOP_DEFINES_SVH
`define DEPENDENCY_GRAPH_TOPO_SORT_CULL_TOP_DEFINES_SVH

// same-cycle implication
`define DGTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DGTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dgts_pkg.sv =====
// ----------------------------------------------------------------------------
// Dependency graph scheduler package
// Word layouts, edge record, command, kind and status codes.
// ----------------------------------------------------------------------------
package dgts_pkg;

    localparam int MAX_NODES = 16;
    localparam int MAX_EDGES = 32;
    localparam int EW        = $clog2(MAX_EDGES);
    localparam int CW        = EW + 1;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] K_ACK  = 3'd0;
    localparam logic [2:0] K_PASS = 3'd1;
    localparam logic [2:0] K_ATT  = 3'd2;
    localparam logic [2:0] K_BAR  = 3'd3;
    localparam logic [2:0] K_DONE = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_EDGE = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NO_OUT   = 3'd3;
    localparam logic [2:0] ST_BAD_OUT  = 3'd4;
    localparam logic [2:0] ST_CYCLE    = 3'd5;

    localparam logic [1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_MASK = 2'd1;

    localparam logic [1:0] U_COLOR = 2'd0;
    localparam logic [1:0] U_DEPTH = 2'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  from_node;
        logic [3:0]  to_node;
        logic [15:0] resource_id;
        logic [3:0]  src_usage;
        logic [3:0]  dst_usage;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  node;
        logic [3:0]  source_node;
        logic [15:0] resource;
        logic [3:0]  usage_before;
        logic [3:0]  usage_after;
        logic [2:0]  status;
        logic [4:0]  pass_count;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [3:0]  from_node;
        logic [3:0]  to_node;
        logic [15:0] res;
        logic [3:0]  su;
        logic [3:0]  du;
    } t_edge;

    typedef struct packed {
        logic          we;
        logic [EW-1:0] waddr;
        t_edge         wdata;
        logic [EW-1:0] raddr;
    } t_mem_req;

    function automatic logic is_attach(input logic [3:0] u);
        return (u == {2'b00, U_COLOR}) || (u == {2'b00, U_DEPTH});
    endfunction

endpackage

// ===== design/dgts_edge_mem.sv =====
// ----------------------------------------------------------------------------
// Edge table memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module dgts_edge_mem (
    input  logic              i_clk,
    input  dgts_pkg::t_mem_req i_req,
    output dgts_pkg::t_edge    o_rd_data
);
    import dgts_pkg::*;

    t_edge mem [MAX_EDGES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rd_data <= mem[i_req.raddr];
    end

endmodule

// ===== design/dgts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Edge loading, in-degree count, Kahn sort, backward cull and plan output.
// ----------------------------------------------------------------------------
module dgts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dgts_pkg::t_in_word  i_word,
    input  logic [4:0]          i_node_count,
    input  logic [15:0]         i_out_mask,
    input  dgts_pkg::t_edge     i_rd_data,
    output logic                o_busy,
    output logic                o_stb,
    output dgts_pkg::t_out_word o_res,
    output dgts_pkg::t_mem_req  o_req
);
    import dgts_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CNT  = 4'd1;
    localparam logic [3:0] S_SEED = 4'd2;
    localparam logic [3:0] S_POP  = 4'd3;
    localparam logic [3:0] S_DEC  = 4'd4;
    localparam logic [3:0] S_CULL = 4'd5;
    localparam logic [3:0] S_ESEL = 4'd6;
    localparam logic [3:0] S_EDEP = 4'd7;

    localparam logic [4:0] NMAX = 5'(MAX_NODES);
    localparam logic [CW-1:0] EMAX = CW'(MAX_EDGES);

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [EW-1:0] r_sw_idx;
    logic          r_sw_on, r_pv, r_pl;
    logic          sw_start;
    logic [5:0]    r_deg [MAX_NODES];
    logic [5:0]    n_deg [MAX_NODES];
    logic [3:0]    r_q [MAX_NODES];
    logic [3:0]    n_q [MAX_NODES];
    logic [4:0]    r_i, n_i, r_head, n_head, r_tail, n_tail, r_kept, n_kept;
    logic [3:0]    r_v, n_v;
    logic [15:0]   r_keep, n_keep;
    logic          r_bad, n_bad, r_chg, n_chg;

    logic [4:0]  nn;
    logic [15:0] vmask;
    logic        sw_done, bad_now, chg_now;
    logic [5:0]  dec;
    logic [3:0]  sel;
    logic [2:0]  st;

    assign nn      = (i_node_count > NMAX) ? NMAX : i_node_count;
    assign vmask   = 16'((17'd1 << nn) - 17'd1);
    assign sw_done = (r_pv && r_pl) || (!r_sw_on && !r_pv);
    assign o_busy  = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_deg   = r_deg;
        n_q     = r_q;
        n_i     = r_i;
        n_head  = r_head;
        n_tail  = r_tail;
        n_kept  = r_kept;
        n_v     = r_v;
        n_keep  = r_keep;
        n_bad   = r_bad;
        n_chg   = r_chg;
        sw_start = 1'b0;
        o_stb   = 1'b0;
        o_res   = '0;
        o_req   = '0;
        o_req.raddr = r_sw_idx;
        bad_now = r_bad;
        chg_now = r_chg;
        dec     = '0;
        sel     = '0;
        st      = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_word.cmd)
                        CMD_ADD: begin
                            if ({1'b0, i_word.from_node} >= nn || {1'b0, i_word.to_node} >= nn
                                || i_word.from_node == i_word.to_node) begin
                                st = ST_BAD_EDGE;
                            end else if (r_cnt >= EMAX) begin
                                st = ST_FULL;
                            end else begin
                                o_req.we    = 1'b1;
                                o_req.waddr = r_cnt[EW-1:0];
                                o_req.wdata = '{from_node: i_word.from_node,
                                                to_node: i_word.to_node,
                                                res: i_word.resource_id,
                                                su: i_word.src_usage,
                                                du: i_word.dst_usage};
                                n_cnt = r_cnt + CW'(1);
                            end
                            o_stb              = 1'b1;
                            o_res.kind         = K_ACK;
                            o_res.node         = i_word.to_node;
                            o_res.source_node  = i_word.from_node;
                            o_res.resource     = i_word.resource_id;
                            o_res.usage_before = i_word.src_usage;
                            o_res.usage_after  = i_word.dst_usage;
                            o_res.status       = st;
                            o_res.last         = 1'b1;
                        end
                        CMD_BUILD: begin
                            n_keep = '0;
                            if (i_out_mask == 16'd0) begin
                                o_stb        = 1'b1;
                                o_res.kind   = K_DONE;
                                o_res.status = ST_NO_OUT;
                                o_res.last   = 1'b1;
                            end else if ((i_out_mask & ~vmask) != 16'd0) begin
                                o_stb        = 1'b1;
                                o_res.kind   = K_DONE;
                                o_res.status = ST_BAD_OUT;
                                o_res.last   = 1'b1;
                            end else begin
                                for (int k = 0; k < MAX_NODES; k++) begin
                                    n_deg[k] = '0;
                                end
                                n_bad    = 1'b0;
                                sw_start = 1'b1;
                                n_state  = S_CNT;
                            end
                        end
                        CMD_CLEAR: begin
                            n_cnt      = '0;
                            o_stb      = 1'b1;
                            o_res.kind = K_ACK;
                            o_res.last = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_CNT: begin
                if (r_pv) begin
                    if ({1'b0, i_rd_data.from_node} >= nn || {1'b0, i_rd_data.to_node} >= nn) begin
                        bad_now = 1'b1;
                    end
                    n_deg[i_rd_data.to_node] = r_deg[i_rd_data.to_node] + 6'd1;
                end
                n_bad = bad_now;
                if (sw_done) begin
                    if (bad_now) begin
                        o_stb        = 1'b1;
                        o_res.kind   = K_DONE;
                        o_res.status = ST_BAD_EDGE;
                        o_res.last   = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_i     = '0;
                        n_head  = '0;
                        n_tail  = '0;
                        n_state = S_SEED;
                    end
                end
            end
            S_SEED: begin
                if (r_i == nn) begin
                    n_state = S_POP;
                end else begin
                    if (r_deg[r_i[3:0]] == 6'd0) begin
                        n_q[r_tail[3:0]] = r_i[3:0];
                        n_tail = r_tail + 5'd1;
                    end
                    n_i = r_i + 5'd1;
                end
            end
            S_POP: begin
                if (r_head == r_tail) begin
                    if (r_tail != nn) begin
                        o_stb        = 1'b1;
                        o_res.kind   = K_DONE;
                        o_res.status = ST_CYCLE;
                        o_res.last   = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_keep   = i_out_mask;
                        n_chg    = 1'b0;
                        sw_start = 1'b1;
                        n_state  = S_CULL;
                    end
                end else begin
                    n_v      = r_q[r_head[3:0]];
                    n_head   = r_head + 5'd1;
                    sw_start = 1'b1;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                if (r_pv && i_rd_data.from_node == r_v) begin
                    dec = r_deg[i_rd_data.to_node] - 6'd1;
                    n_deg[i_rd_data.to_node] = dec;
                    if (dec == 6'd0 && r_tail < NMAX) begin
                        n_q[r_tail[3:0]] = i_rd_data.to_node;
                        n_tail = r_tail + 5'd1;
                    end
                end
                if (sw_done) begin
                    n_state = S_POP;
                end
            end
            S_CULL: begin
                if (r_pv && r_keep[i_rd_data.to_node] && !r_keep[i_rd_data.from_node]) begin
                    n_keep[i_rd_data.from_node] = 1'b1;
                    chg_now = 1'b1;
                end
                n_chg = chg_now;
                if (sw_done) begin
                    if (chg_now) begin
                        n_chg    = 1'b0;
                        sw_start = 1'b1;
                    end else begin
                        n_i     = '0;
                        n_kept  = '0;
                        n_state = S_ESEL;
                    end
                end
            end
            S_ESEL: begin
                if (r_i == nn) begin
                    o_stb            = 1'b1;
                    o_res.kind       = K_DONE;
                    o_res.pass_count = r_kept;
                    o_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    sel = r_q[r_i[3:0]];
                    if (r_keep[sel]) begin
                        o_stb      = 1'b1;
                        o_res.kind = K_PASS;
                        o_res.node = sel;
                        n_kept     = r_kept + 5'd1;
                        n_v        = sel;
                        sw_start   = 1'b1;
                        n_state    = S_EDEP;
                    end else begin
                        n_i = r_i + 5'd1;
                    end
                end
            end
            S_EDEP: begin
                if (r_pv && i_rd_data.to_node == r_v) begin
                    o_stb              = 1'b1;
                    o_res.kind         = (is_attach(i_rd_data.su) && is_attach(i_rd_data.du))
                                         ? K_ATT : K_BAR;
                    o_res.node         = i_rd_data.to_node;
                    o_res.source_node  = i_rd_data.from_node;
                    o_res.resource     = i_rd_data.res;
                    o_res.usage_before = i_rd_data.su;
                    o_res.usage_after  = i_rd_data.du;
                end
                if (sw_done) begin
                    n_i     = r_i + 5'd1;
                    n_state = S_ESEL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sw_on  <= 1'b0;
            r_pv     <= 1'b0;
            r_pl     <= 1'b0;
            r_sw_idx <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (sw_start) begin
                r_sw_idx <= '0;
                r_sw_on  <= (r_cnt != '0);
                r_pv     <= 1'b0;
                r_pl     <= 1'b0;
            end else begin
                r_pv <= r_sw_on;
                r_pl <= r_sw_on && ({1'b0, r_sw_idx} == r_cnt - CW'(1));
                if (r_sw_on) begin
                    r_sw_idx <= r_sw_idx + EW'(1);
                    if ({1'b0, r_sw_idx} == r_cnt - CW'(1)) begin
                        r_sw_on <= 1'b0;
                    end
                end
            end
        end
        r_deg  <= n_deg;
        r_q    <= n_q;
        r_i    <= n_i;
        r_head <= n_head;
        r_tail <= n_tail;
        r_kept <= n_kept;
        r_v    <= n_v;
        r_keep <= n_keep;
        r_bad  <= n_bad;
        r_chg  <= n_chg;
    end

endmodule

// ===== design/dependency_graph_topo_sort_cull_top.sv =====
// Edge add and clear: the acknowledge word appears in the cycle after start.
// Build reads one edge per cycle, sweeping the table to count in-degrees, then
// per sorted node, per cull pass until the retained set settles, per kept pass.
// Words leave one per cycle at most; the plan-done word carries last.
// Synchronous active-low reset empties the edge table and clears both registers.
// ----------------------------------------------------------------------------
// Dependency graph scheduler top
// Config registers, edge memory, sequencer and registered result word.
// ----------------------------------------------------------------------------
`include "dependency_graph_topo_sort_cull_top_defines.svh"

module dependency_graph_topo_sort_cull_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  dgts_pkg::t_in_word  i_word,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output logic                o_strobe,
    output dgts_pkg::t_out_word o_word
);
    import dgts_pkg::*;

    logic [4:0]  r_node_count;
    logic [15:0] r_out_mask;
    logic        r_stb, stb;
    t_out_word   r_word, res;
    t_mem_req    req;
    t_edge       rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_out_mask   <= '0;
            r_stb        <= 1'b0;
        end else begin
            r_stb <= stb;
            if (i_cfg_we && i_cfg_idx == CFG_NODE_COUNT) begin
                r_node_count <= i_cfg_data[4:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_OUTPUT_MASK) begin
                r_out_mask <= i_cfg_data;
            end
        end
        r_word <= res;
    end

    dgts_edge_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    dgts_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_word       (i_word),
        .i_node_count (r_node_count),
        .i_out_mask   (r_out_mask),
        .i_rd_data    (rd_data),
        .o_busy       (o_busy),
        .o_stb        (stb),
        .o_res        (res),
        .o_req        (req)
    );

    assign o_strobe = r_stb;
    assign o_word   = r_word;

    `DGTS_ASSERT_IMP(a_last_idle, o_strobe && o_word.last, !o_busy, "last word while busy")
    `DGTS_ASSERT_NXT(a_add_ack, i_start && !o_busy && i_word.cmd == CMD_ADD, o_strobe && o_word.last && o_word.kind == K_ACK, "add not acknowledged")
    `DGTS_ASSERT_IMP(a_pass_mid, o_strobe && o_word.kind == K_PASS, !o_word.last && o_word.status == ST_OK, "pass word malformed")

endmodule
